@@ design/pidct_pkg.sv @@
package pidct_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned LimitW  = 15;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned WideW   = 26;

  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_THRESH = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ERROR_LIMIT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PROP_LIMIT  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_LIMIT = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_OUTPUT_LIMIT = 3'd7;

  typedef struct packed {
    logic signed [SampleW-1:0] prop_gain;
    logic signed [SampleW-1:0] integ_gain;
    logic signed [SampleW-1:0] deriv_gain;
    logic signed [SampleW-1:0] integral_threshold;
    logic [LimitW-1:0]         error_limit;
    logic [LimitW-1:0]         prop_limit;
    logic [LimitW-1:0]         integ_limit;
    logic [LimitW-1:0]         output_limit;
  } pidct_cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] setpoint;
    logic signed [SampleW-1:0] measured;
    logic                      clear_history;
  } pidct_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] drive;
    logic signed [SampleW-1:0] p_term;
    logic signed [SampleW-1:0] i_term;
    logic signed [SampleW-1:0] d_term;
  } pidct_result_t;

  typedef struct packed {
    logic signed [SampleW-1:0] prev_err;
    logic signed [SampleW-1:0] integ;
  } pidct_state_t;

  // symmetric clamp to +/- lim, result fits 16 bits since lim < 2^15
  function automatic logic signed [SampleW-1:0] clamp_sym(
    input logic signed [WideW-1:0] v,
    input logic [LimitW-1:0]       lim
  );
    logic signed [WideW-1:0] pos;
    logic signed [WideW-1:0] neg;
    logic signed [WideW-1:0] res;
    pos = $signed({{(WideW-LimitW){1'b0}}, lim});
    neg = -pos;
    if (v > pos) begin
      res = pos;
    end else if (v < neg) begin
      res = neg;
    end else begin
      res = v;
    end
    return res[SampleW-1:0];
  endfunction

endpackage

@@ design/pidct_if.sv @@
interface pidct_in_if import pidct_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] setpoint;
  logic signed [SampleW-1:0] measured;
  logic                      clear_history;

  modport source (output valid, setpoint, measured, clear_history, input ready);
  modport sink (input valid, setpoint, measured, clear_history, output ready);
endinterface

interface pidct_out_if import pidct_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] drive;
  logic signed [SampleW-1:0] p_term;
  logic signed [SampleW-1:0] i_term;
  logic signed [SampleW-1:0] d_term;

  modport source (output valid, drive, p_term, i_term, d_term, input ready);
  modport sink (input valid, drive, p_term, i_term, d_term, output ready);
endinterface

@@ design/pidct_cfg_regs.sv @@
module pidct_cfg_regs import pidct_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output pidct_cfg_t          cfg
);

  pidct_cfg_t cfg_r;
  pidct_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:    cfg_nxt.prop_gain          = $signed(cfg_wdata);
        CFG_INTEG_GAIN:   cfg_nxt.integ_gain         = $signed(cfg_wdata);
        CFG_DERIV_GAIN:   cfg_nxt.deriv_gain         = $signed(cfg_wdata);
        CFG_INTEG_THRESH: cfg_nxt.integral_threshold = $signed(cfg_wdata);
        CFG_ERROR_LIMIT:  cfg_nxt.error_limit        = cfg_wdata[LimitW-1:0];
        CFG_PROP_LIMIT:   cfg_nxt.prop_limit         = cfg_wdata[LimitW-1:0];
        CFG_INTEG_LIMIT:  cfg_nxt.integ_limit        = cfg_wdata[LimitW-1:0];
        CFG_OUTPUT_LIMIT: cfg_nxt.output_limit       = cfg_wdata[LimitW-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain          <= '0;
      cfg_r.integ_gain         <= '0;
      cfg_r.deriv_gain         <= '0;
      cfg_r.integral_threshold <= 16'sh7FFF;
      cfg_r.error_limit        <= '1;
      cfg_r.prop_limit         <= '1;
      cfg_r.integ_limit        <= '1;
      cfg_r.output_limit       <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/pidct_datapath.sv @@
module pidct_datapath import pidct_pkg::*; #(
  parameter int unsigned D_LIMIT = 32767
) (
  input  pidct_cfg_t    cfg,
  input  pidct_item_t   item,
  input  pidct_state_t  state,
  output pidct_result_t result,
  output pidct_state_t  state_nxt
);

  localparam logic [LimitW-1:0] DLim = LimitW'(D_LIMIT);

  logic signed [SampleW:0]     err_raw;
  logic signed [SampleW-1:0]   err;
  logic signed [2*SampleW-1:0] p_prod;
  logic signed [2*SampleW-1:0] i_prod;
  logic signed [SampleW:0]     err_diff;
  logic signed [2*SampleW+1:0] d_prod;
  logic signed [WideW-1:0]     i_acc;
  logic signed [SampleW-1:0]   p_val;
  logic signed [SampleW-1:0]   i_val;
  logic signed [SampleW-1:0]   d_val;
  logic signed [SampleW+1:0]   sum;
  logic signed [SampleW-1:0]   drive_val;

  assign err_raw = $signed({item.setpoint[SampleW-1], item.setpoint})
                 - $signed({item.measured[SampleW-1], item.measured});
  assign err = clamp_sym(WideW'(err_raw), cfg.error_limit);

  assign p_prod = cfg.prop_gain * err;
  assign p_val  = clamp_sym(WideW'($signed(p_prod[2*SampleW-1:8])), cfg.prop_limit);

  assign i_prod = cfg.integ_gain * err;
  assign i_acc  = WideW'(state.integ) + WideW'($signed(i_prod[2*SampleW-1:8]));
  assign i_val  = (err < cfg.integral_threshold) ? clamp_sym(i_acc, cfg.integ_limit)
                                                 : '0;

  assign err_diff = $signed({err[SampleW-1], err})
                  - $signed({state.prev_err[SampleW-1], state.prev_err});
  assign d_prod = $signed({cfg.deriv_gain[SampleW-1], cfg.deriv_gain}) * err_diff;
  assign d_val  = clamp_sym($signed(d_prod[WideW+7:8]), DLim);

  assign sum = (SampleW+2)'(p_val) + (SampleW+2)'(i_val) + (SampleW+2)'(d_val);
  assign drive_val = clamp_sym(WideW'(sum), cfg.output_limit);

  always_comb begin
    if (item.clear_history) begin
      result    = '0;
      state_nxt = '0;
    end else begin
      result.drive       = drive_val;
      result.p_term      = p_val;
      result.i_term      = i_val;
      result.d_term      = d_val;
      state_nxt.prev_err = err;
      state_nxt.integ    = i_val;
    end
  end

endmodule

@@ design/pid_controller_clamped_terms_core.sv @@
// PID step with clamped P, I and D terms and integral separation. Each accepted word
// (setpoint, measured, clear_history) yields one result word (drive, p_term, i_term,
// d_term) via the input and result registers; one word per cycle is sustained while
// out_ch.ready is high. The input register feeds a combinational term datapath whose
// updated error and integral are written back in the same cycle the result register
// loads, so successive words see their predecessor's state. in_ch.ready drops only
// while both registers hold words and the result is stalled. Gains are signed Q8.8;
// products shift right by 8 rounding to minus infinity. The user must write registers via
// cfg_we/cfg_index/cfg_wdata only while no word is in flight; not enforced by the block.
module pid_controller_clamped_terms_core import pidct_pkg::*; #(
  parameter int unsigned D_LIMIT = 32767
) (
  input  logic                clk,
  input  logic                rst_n,
  pidct_in_if.sink            in_ch,
  pidct_out_if.source         out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  pidct_cfg_t    cfg;
  pidct_item_t   item_r;
  logic          item_vld_r;
  pidct_result_t result;
  pidct_result_t res_r;
  logic          res_vld_r;
  pidct_state_t  state_r;
  pidct_state_t  state_nxt;
  logic          adv;
  logic          in_acc;

  pidct_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidct_datapath #(.D_LIMIT(D_LIMIT)) u_dp (
    .cfg       (cfg),
    .item      (item_r),
    .state     (state_r),
    .result    (result),
    .state_nxt (state_nxt)
  );

  assign adv         = item_vld_r && (!res_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      state_r    <= '0;
    end else begin
      if (in_ch.ready) begin
        item_vld_r <= in_ch.valid;
      end
      if (adv) begin
        res_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_ch.ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.setpoint      <= in_ch.setpoint;
      item_r.measured      <= in_ch.measured;
      item_r.clear_history <= in_ch.clear_history;
    end
    if (adv) begin
      res_r <= result;
    end
  end

  assign out_ch.valid  = res_vld_r;
  assign out_ch.drive  = res_r.drive;
  assign out_ch.p_term = res_r.p_term;
  assign out_ch.i_term = res_r.i_term;
  assign out_ch.d_term = res_r.d_term;

  a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (item_vld_r && res_vld_r && !out_ch.ready))
    else $error("input stalled while a stage is free");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("controller state changed without a word moving");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item_r.clear_history) |=> (state_r == '0 && out_ch.drive == '0 &&
      out_ch.p_term == '0 && out_ch.i_term == '0 && out_ch.d_term == '0))
    else $error("clear request left history or result nonzero");

  a_integ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_ch.i_term == state_r.integ))
    else $error("reported integral differs from stored integral");

endmodule
